### sv/subpicture_rle_run_decoder_core_defines.svh
// ----------------------------------------------------------------------------
// Subpicture run decoder assertion macros
// Shared assertion forms for the checker of the run decoder core.
// ----------------------------------------------------------------------------
`ifndef SUBPICTURE_RLE_RUN_DECODER_CORE_DEFINES_SVH
`define SUBPICTURE_RLE_RUN_DECODER_CORE_DEFINES_SVH

// Check a same-cycle implication, quiet while in reset
`define SRD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check a next-cycle implication, quiet while in reset
`define SRD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/srd_pkg.sv
// ----------------------------------------------------------------------------
// srd_pkg
// Shared types and constants of the subpicture run decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package srd_pkg;

	// Field and state widths
	localparam int unsigned DIM_W   = 13;
	localparam int unsigned COL_W   = 12;
	localparam int unsigned NIB_W   = 4;
	localparam int unsigned MAP_W   = 16;

	// Configuration port
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PALETTE_MAP  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_MAP    = 2'd3;

	// Register reset values and line width limit
	localparam logic [DIM_W-1:0] WIDTH_RST  = 13'd720;
	localparam logic [DIM_W-1:0] HEIGHT_RST = 13'd576;
	localparam logic [DIM_W-1:0] MAX_LINE_W = 13'd4096;

	// Code completion thresholds after one, two and three nibbles
	localparam logic [9:0] CODE_MIN1 = 10'h004;
	localparam logic [9:0] CODE_MIN2 = 10'h010;
	localparam logic [9:0] CODE_MIN3 = 10'h040;

	// Queue sizes
	localparam int unsigned BQ_DEPTH = 4;
	localparam int unsigned BQ_AW    = 2;
	localparam int unsigned OQ_DEPTH = 4;
	localparam int unsigned OQ_AW    = 2;

	// One accepted byte, split and pre-classified
	typedef struct packed {
		logic             start;
		logic [NIB_W-1:0] hi;
		logic [NIB_W-1:0] lo;
		logic             hi_one;
		logic             lo_one;
	} byte_entry_t;

	// One result word
	typedef struct packed {
		logic [1:0]       pixel_code;
		logic [3:0]       palette_color;
		logic [3:0]       alpha_value;
		logic [DIM_W-1:0] run_length;
		logic [COL_W-1:0] start_column;
		logic [COL_W-1:0] line_number;
		logic             line_end;
		logic             next_field;
		logic             last_of_byte;
	} run_t;

	// Configuration register set
	typedef struct packed {
		logic [DIM_W-1:0] image_width;
		logic [DIM_W-1:0] image_height;
		logic [MAP_W-1:0] palette_map;
		logic [MAP_W-1:0] alpha_map;
	} cfg_t;

endpackage

`default_nettype wire

### sv/subpicture_rle_run_decoder_core.sv
// ----------------------------------------------------------------------------
// subpicture_rle_run_decoder_core
// Run-length subpicture decoder: bytes in, clipped colored runs out.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue: drive data_byte/picture_start with push; a word is taken on
//   a clock edge with push high and full low. picture_start clears position,
//   field and code state ahead of that byte; registers keep their values.
//   Result queue: while empty is low the oldest run is on the result ports;
//   pop takes it. A byte gives zero, one or two runs, all released together.
//   Config: write image_width, image_height, palette_map, alpha_map through
//   cfg_valid/cfg_index/cfg_data (cfg_ready is always high) while idle.
//   Throughput: the back engine decodes one nibble per cycle while a byte
//   is queued and the result queue has room for two words; a byte whose
//   high nibble ends a line is done after that nibble. A byte is held in
//   the input stage register and the byte queue before it is decoded.
//   A stalled result side fills the 4-word result queue, then the 4-word byte
//   queue and input stage, after which full rises; nothing is dropped.
//   Reset: queues empty, position and code state zero, width 720, height
//   576, both maps zero.
// ----------------------------------------------------------------------------
`default_nettype none

module subpicture_rle_run_decoder_core (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             push,
	output logic                                  full,
	input  wire logic [7:0]                       data_byte,
	input  wire logic                             picture_start,
	output logic                                  empty,
	input  wire logic                             pop,
	output logic [1:0]                            pixel_code,
	output logic [3:0]                            palette_color,
	output logic [3:0]                            alpha_value,
	output logic [srd_pkg::DIM_W-1:0]             run_length,
	output logic [srd_pkg::COL_W-1:0]             start_column,
	output logic [srd_pkg::COL_W-1:0]             line_number,
	output logic                                  line_end,
	output logic                                  next_field,
	output logic                                  last_of_byte,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [srd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [srd_pkg::CFG_DATA_W-1:0]   cfg_data
);

	srd_pkg::cfg_t        cfg_q;
	logic                 bq_push;
	srd_pkg::byte_entry_t bq_wr;
	logic                 bq_full;
	logic                 bq_pop;
	logic                 bq_valid;
	srd_pkg::byte_entry_t bq_head;
	logic                 oq_room2;
	logic                 wr_a;
	logic                 wr_b;
	srd_pkg::run_t        data_a;
	srd_pkg::run_t        data_b;
	srd_pkg::run_t        oq_head;

	assign cfg_ready = 1'b1;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.image_width  <= srd_pkg::WIDTH_RST;
			cfg_q.image_height <= srd_pkg::HEIGHT_RST;
			cfg_q.palette_map  <= '0;
			cfg_q.alpha_map    <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				srd_pkg::CFG_IMAGE_WIDTH:
					cfg_q.image_width <= cfg_data[srd_pkg::DIM_W-1:0];
				srd_pkg::CFG_IMAGE_HEIGHT:
					cfg_q.image_height <= cfg_data[srd_pkg::DIM_W-1:0];
				srd_pkg::CFG_PALETTE_MAP:
					cfg_q.palette_map <= cfg_data;
				srd_pkg::CFG_ALPHA_MAP:
					cfg_q.alpha_map <= cfg_data;
			endcase
		end
	end

	srd_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.data_byte     (data_byte),
		.picture_start (picture_start),
		.q_full        (bq_full),
		.q_push        (bq_push),
		.q_data        (bq_wr)
	);

	srd_byte_queue u_byte_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (bq_push),
		.wr_data (bq_wr),
		.full    (bq_full),
		.pop     (bq_pop),
		.valid   (bq_valid),
		.head    (bq_head)
	);

	srd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_valid   (bq_valid),
		.q_head    (bq_head),
		.q_pop     (bq_pop),
		.out_room2 (oq_room2),
		.wr_a      (wr_a),
		.wr_b      (wr_b),
		.data_a    (data_a),
		.data_b    (data_b)
	);

	srd_out_queue u_out_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_a   (wr_a),
		.wr_b   (wr_b),
		.data_a (data_a),
		.data_b (data_b),
		.room2  (oq_room2),
		.pop    (pop),
		.empty  (empty),
		.head   (oq_head)
	);

	// Drive the result ports from the queue head
	assign pixel_code    = oq_head.pixel_code;
	assign palette_color = oq_head.palette_color;
	assign alpha_value   = oq_head.alpha_value;
	assign run_length    = oq_head.run_length;
	assign start_column  = oq_head.start_column;
	assign line_number   = oq_head.line_number;
	assign line_end      = oq_head.line_end;
	assign next_field    = oq_head.next_field;
	assign last_of_byte  = oq_head.last_of_byte;

endmodule

`default_nettype wire

### sv/srd_front.sv
// ----------------------------------------------------------------------------
// srd_front
// Input stage: takes bytes, splits them into nibbles and flags short codes.
// ----------------------------------------------------------------------------
`default_nettype none

module srd_front (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	output logic                     full,
	input  wire logic [7:0]          data_byte,
	input  wire logic                picture_start,
	input  wire logic                q_full,
	output logic                     q_push,
	output srd_pkg::byte_entry_t     q_data
);

	logic                 valid_s1;
	srd_pkg::byte_entry_t entry_s1;
	srd_pkg::byte_entry_t entry_d;
	logic                 accept;

	// Split the byte; a nibble of 0x4 or more is a complete code on its own
	always_comb begin
		entry_d.start  = picture_start;
		entry_d.hi     = data_byte[7:4];
		entry_d.lo     = data_byte[3:0];
		entry_d.hi_one = ({6'd0, data_byte[7:4]} >= srd_pkg::CODE_MIN1);
		entry_d.lo_one = ({6'd0, data_byte[3:0]} >= srd_pkg::CODE_MIN1);
	end

	// Stall only when the stage holds a word and the queue is full
	assign full   = valid_s1 & q_full;
	assign accept = push & ~full;
	assign q_push = valid_s1 & ~q_full;
	assign q_data = entry_s1;

	// Hold the stage valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (q_push) begin
			valid_s1 <= 1'b0;
		end
	end

	// Capture the payload
	always_ff @(posedge clk) begin
		if (accept) begin
			entry_s1 <= entry_d;
		end
	end

endmodule

`default_nettype wire

### sv/srd_byte_queue.sv
// ----------------------------------------------------------------------------
// srd_byte_queue
// Short queue of classified bytes between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module srd_byte_queue (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push,
	input  wire srd_pkg::byte_entry_t wr_data,
	output logic                      full,
	input  wire logic                 pop,
	output logic                      valid,
	output srd_pkg::byte_entry_t      head
);

	srd_pkg::byte_entry_t           mem_q [srd_pkg::BQ_DEPTH];
	logic [srd_pkg::BQ_AW-1:0]      wr_ptr_q;
	logic [srd_pkg::BQ_AW-1:0]      rd_ptr_q;
	logic [srd_pkg::BQ_AW:0]        count_q;
	logic                           do_push;
	logic                           do_pop;

	assign full    = (count_q == (srd_pkg::BQ_AW+1)'(srd_pkg::BQ_DEPTH));
	assign valid   = (count_q != '0);
	assign head    = mem_q[rd_ptr_q];
	assign do_push = push & ~full;
	assign do_pop  = pop & valid;

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + srd_pkg::BQ_AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + srd_pkg::BQ_AW'(1);
			end
			count_q <= count_q + (srd_pkg::BQ_AW+1)'(do_push)
				- (srd_pkg::BQ_AW+1)'(do_pop);
		end
	end

	// Store the word
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

`default_nettype wire

### sv/srd_back.sv
// ----------------------------------------------------------------------------
// srd_back
// Run engine: codes one nibble a cycle if unstalled, clips runs, tracks place.
// ----------------------------------------------------------------------------
`default_nettype none

module srd_back (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire srd_pkg::cfg_t        cfg,
	input  wire logic                 q_valid,
	input  wire srd_pkg::byte_entry_t q_head,
	output logic                      q_pop,
	input  wire logic                 out_room2,
	output logic                      wr_a,
	output logic                      wr_b,
	output srd_pkg::run_t             data_a,
	output srd_pkg::run_t             data_b
);

	localparam logic PH_HI = 1'b0;
	localparam logic PH_LO = 1'b1;

	logic                         phase_q;
	logic [srd_pkg::COL_W-1:0]    col_q;
	logic [srd_pkg::DIM_W-1:0]    line_q;
	logic                         field_q;
	logic [5:0]                   acc_q;
	logic [1:0]                   held_q;
	logic                         pend_valid_q;
	srd_pkg::run_t                pend_q;

	logic                         step;
	logic                         clear;
	logic [srd_pkg::COL_W-1:0]    eff_col;
	logic [srd_pkg::DIM_W-1:0]    eff_line;
	logic                         eff_field;
	logic [5:0]                   eff_acc;
	logic [1:0]                   eff_held;
	logic [srd_pkg::NIB_W-1:0]    nib;
	logic                         nib_one;
	logic [2:0]                   held_n;
	logic [9:0]                   acc_n;
	logic                         done;
	logic [7:0]                   len;
	logic [1:0]                   code;
	logic [srd_pkg::DIM_W-1:0]    w;
	logic [srd_pkg::DIM_W-1:0]    x13;
	logic [srd_pkg::DIM_W-1:0]    len13;
	logic                         past;
	logic [srd_pkg::DIM_W-1:0]    avail;
	logic                         len_zero;
	logic                         fill_skip;
	logic [srd_pkg::DIM_W-1:0]    run;
	logic                         line_done;
	logic                         emit;
	logic                         ends;
	logic [srd_pkg::DIM_W-1:0]    col_adv;
	logic                         byte_fin;
	logic                         field_new;
	srd_pkg::run_t                cur;

	assign step  = q_valid & out_room2;
	assign clear = (phase_q == PH_HI) & q_head.start;

	// Apply picture start ahead of the high nibble
	assign eff_col   = clear ? '0 : col_q;
	assign eff_line  = clear ? '0 : line_q;
	assign eff_field = clear ? 1'b0 : field_q;
	assign eff_acc   = clear ? '0 : acc_q;
	assign eff_held  = clear ? '0 : held_q;

	// Pick the nibble of this cycle and extend the code
	assign nib     = (phase_q == PH_HI) ? q_head.hi : q_head.lo;
	assign nib_one = (phase_q == PH_HI) ? q_head.hi_one : q_head.lo_one;
	assign held_n  = {1'b0, eff_held} + 3'd1;
	assign acc_n   = {eff_acc, nib};

	// Decide whether the code is complete
	always_comb begin
		unique case (eff_held)
			2'd0: done = nib_one;
			2'd1: done = (acc_n >= srd_pkg::CODE_MIN2);
			2'd2: done = (acc_n >= srd_pkg::CODE_MIN3);
			2'd3: done = 1'b1;
		endcase
	end

	assign len  = acc_n[9:2];
	assign code = acc_n[1:0];

	// Clip the run to the line
	assign w         = (cfg.image_width > srd_pkg::MAX_LINE_W) ? srd_pkg::MAX_LINE_W
		: cfg.image_width;
	assign x13       = {1'b0, eff_col};
	assign len13     = {5'd0, len};
	assign past      = (x13 >= w);
	assign avail     = past ? '0 : (w - x13);
	assign len_zero  = (len == '0);
	assign fill_skip = len_zero & (eff_line >= cfg.image_height);
	assign run       = (len_zero | (len13 > avail)) ? avail : len13;
	assign line_done = past | len_zero | (len13 >= avail);
	assign emit      = done & ~fill_skip;
	assign ends      = emit & line_done;
	assign col_adv   = x13 + len13;

	// A byte finishes after its low nibble or at a line end on the high one
	assign byte_fin  = (phase_q == PH_LO) | ends;
	assign field_new = eff_field ^ ends;
	assign q_pop     = step & byte_fin;

	// Assemble the run of this cycle
	always_comb begin
		cur.pixel_code    = code;
		cur.palette_color = cfg.palette_map[{code, 2'b00} +: 4];
		cur.alpha_value   = cfg.alpha_map[{code, 2'b00} +: 4];
		cur.run_length    = run;
		cur.start_column  = eff_col;
		cur.line_number   = eff_line[srd_pkg::COL_W-1:0];
		cur.line_end      = line_done;
		cur.next_field    = field_new;
		cur.last_of_byte  = 1'b1;
	end

	// Release the held run with its flags settled, then this cycle's run
	always_comb begin
		data_a = cur;
		data_b = cur;
		wr_a   = 1'b0;
		wr_b   = 1'b0;
		if (step && byte_fin) begin
			if (pend_valid_q) begin
				data_a              = pend_q;
				data_a.next_field   = field_new;
				data_a.last_of_byte = ~emit;
				wr_a                = 1'b1;
				wr_b                = emit;
			end else begin
				wr_a = emit;
			end
		end
	end

	// Advance code, position and phase state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_HI;
			col_q        <= '0;
			line_q       <= '0;
			field_q      <= 1'b0;
			acc_q        <= '0;
			held_q       <= '0;
			pend_valid_q <= 1'b0;
		end else if (step) begin
			if (done) begin
				acc_q  <= '0;
				held_q <= '0;
			end else begin
				acc_q  <= acc_n[5:0];
				held_q <= held_n[1:0];
			end
			if (ends) begin
				col_q   <= '0;
				line_q  <= eff_line + srd_pkg::DIM_W'(1);
				field_q <= ~eff_field;
			end else if (emit) begin
				col_q   <= col_adv[srd_pkg::COL_W-1:0];
				line_q  <= eff_line;
				field_q <= eff_field;
			end else begin
				col_q   <= eff_col;
				line_q  <= eff_line;
				field_q <= eff_field;
			end
			if (byte_fin) begin
				phase_q      <= PH_HI;
				pend_valid_q <= 1'b0;
			end else begin
				phase_q      <= PH_LO;
				pend_valid_q <= emit;
			end
		end
	end

	// Hold a high-nibble run until the byte is finished
	always_ff @(posedge clk) begin
		if (step && !byte_fin && emit) begin
			pend_q <= cur;
		end
	end

endmodule

`default_nettype wire

### sv/srd_out_queue.sv
// ----------------------------------------------------------------------------
// srd_out_queue
// Result queue: takes up to two words a cycle, hands out one a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module srd_out_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          wr_a,
	input  wire logic          wr_b,
	input  wire srd_pkg::run_t data_a,
	input  wire srd_pkg::run_t data_b,
	output logic               room2,
	input  wire logic          pop,
	output logic               empty,
	output srd_pkg::run_t      head
);

	srd_pkg::run_t                mem_q [srd_pkg::OQ_DEPTH];
	logic [srd_pkg::OQ_AW-1:0]    wr_ptr_q;
	logic [srd_pkg::OQ_AW-1:0]    rd_ptr_q;
	logic [srd_pkg::OQ_AW:0]      count_q;
	logic                         do_pop;
	logic [srd_pkg::OQ_AW-1:0]    wr_ptr_b;
	logic [srd_pkg::OQ_AW:0]      n_wr;

	assign room2    = (count_q <= (srd_pkg::OQ_AW+1)'(srd_pkg::OQ_DEPTH - 2));
	assign empty    = (count_q == '0);
	assign head     = mem_q[rd_ptr_q];
	assign do_pop   = pop & ~empty;
	assign wr_ptr_b = wr_ptr_q + srd_pkg::OQ_AW'(1);
	assign n_wr     = (srd_pkg::OQ_AW+1)'(wr_a) + (srd_pkg::OQ_AW+1)'(wr_b);

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + n_wr[srd_pkg::OQ_AW-1:0];
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + srd_pkg::OQ_AW'(1);
			end
			count_q <= count_q + n_wr - (srd_pkg::OQ_AW+1)'(do_pop);
		end
	end

	// Store the words in order
	always_ff @(posedge clk) begin
		if (wr_a) begin
			mem_q[wr_ptr_q] <= data_a;
		end
		if (wr_b) begin
			mem_q[wr_ptr_b] <= data_b;
		end
	end

endmodule

`default_nettype wire

### sv/srd_checker.sv
// ----------------------------------------------------------------------------
// srd_checker
// Port-level checks on the result queue of the run decoder core.
// ----------------------------------------------------------------------------
`default_nettype none

`include "subpicture_rle_run_decoder_core_defines.svh"

module srd_checker (
	input wire logic                             clk,
	input wire logic                             arst_n,
	input wire logic                             empty,
	input wire logic                             pop,
	input wire logic [srd_pkg::DIM_W-1:0]        run_length,
	input wire logic [srd_pkg::COL_W-1:0]        start_column,
	input wire logic                             line_end
);

	logic [srd_pkg::DIM_W:0] run_stop;

	assign run_stop = {2'b00, start_column} + {1'b0, run_length};

	// A clipped-away run only happens at or past the line end
	`SRD_ASSERT_NOW(a_zero_run_ends_line, !empty && run_length == '0, line_end, "zero-length run without line end")

	// A run never reaches past the widest line
	`SRD_ASSERT_NOW(a_run_in_line, !empty, run_stop <= {1'b0, srd_pkg::MAX_LINE_W}, "run passes the widest line")

	// A waiting word stays until taken
	`SRD_ASSERT_NEXT(a_head_kept, !empty && !pop, !empty, "waiting result vanished")

	// Length and start column of a waiting word do not change until taken
	`SRD_ASSERT_NEXT(a_head_stable, !empty && !pop, $stable(run_length) && $stable(start_column), "waiting result changed")

endmodule

bind subpicture_rle_run_decoder_core srd_checker u_srd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.empty        (empty),
	.pop          (pop),
	.run_length   (run_length),
	.start_column (start_column),
	.line_end     (line_end)
);

`default_nettype wire
